// ----- rtl/sfl_pkg.sv -----
// Package: widths, register map, reset values and LFO table functions for the stereo flanger.
package sfl_pkg;

  localparam int DelayDepthDef   = 2048;
  localparam int SampleWidthDef  = 16;
  localparam int SineDepth       = 256;
  localparam int SineBits        = 8;
  localparam int PhaseWidth      = 24;

  localparam int RegCount = 7;
  localparam int AddrWidth = 5;

  typedef enum logic [2:0] {
    REG_BYPASS   = 3'd0,
    REG_STEREO   = 3'd1,
    REG_STEP     = 3'd2,
    REG_BASE     = 3'd3,
    REG_DEPTH    = 3'd4,
    REG_FEEDBACK = 3'd5,
    REG_WET      = 3'd6
  } reg_idx_t;

  localparam logic [23:0] StepReset     = 24'd95;
  localparam logic [17:0] BaseReset     = 18'd56448;
  localparam logic [15:0] DepthReset    = 16'd16384;
  localparam logic [15:0] FeedbackReset = 16'd16384;
  localparam logic [15:0] WetReset      = 16'd16384;
  localparam logic [16:0] UnityQ15      = 17'd32768;
  localparam logic signed [16:0] FbLimit = 17'sd32440;

  // Quarter-wave Taylor series in Q30, evaluated at elaboration only.
  function automatic longint unsigned quarter_sine(longint unsigned t);
    longint unsigned t2, v, s;
    t2 = (t * t) >> 16;
    v = 64'd172272;
    v = 64'd5026995 - ((t2 * v) >> 16);
    v = 64'd85569306 - ((t2 * v) >> 16);
    v = 64'd693598669 - ((t2 * v) >> 16);
    v = 64'd1686629713 - ((t2 * v) >> 16);
    s = (t * v) >> 16;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s;
  endfunction

  function automatic logic [15:0] lfo_entry(logic [SineBits-1:0] k);
    longint unsigned u, q, t;
    longint s;
    u = (longint'(k) * 262144) / SineDepth;
    q = (u >> 16) & 3;
    t = u & 64'hFFFF;
    if (q[0]) t = 65536 - t;
    s = longint'(quarter_sine(t));
    if (q >= 2) s = -s;
    return 16'((32768 + s) >>> 1);
  endfunction

endpackage

// ----- rtl/stereo_flanger_core.sv -----
// Top level: stereo flanger with a shared multiply-accumulate unit under a sequencer.
// Each frame steps through the sequencer states from input transfer to output valid; bypass goes
// straight from the idle state to the output state. The sequencer runs every product of a frame
// through one 18x26 multiplier and takes no new frame until the last is output; a held output stalls the next.
// Reset (rst, synchronous): registers take defaults, LFO phase and write position clear,
// then a clearing pass zeroes both stores, one entry a cycle, and no input is accepted.
module stereo_flanger_core #(
  parameter int DELAY_DEPTH = sfl_pkg::DelayDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] left_in, [31:16] right_in
  input  logic        s_tlast,   // block_end_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
  output logic        m_tlast,   // block_end_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sfl_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfl_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam logic [AW+7:0] Limit = (AW+8)'(DELAY_DEPTH - 2) << 8;

  typedef enum logic [18:0] {
    S_CLEAR = 19'h00001, S_IDLE  = 19'h00002, S_LFO   = 19'h00004,
    S_DEP   = 19'h00008, S_DLY   = 19'h00010, S_ADDR  = 19'h00020,
    S_RD0   = 19'h00040, S_RD1   = 19'h00080, S_IL0   = 19'h00100,
    S_IL1   = 19'h00200, S_IR0   = 19'h00400, S_IR1   = 19'h00800,
    S_FL    = 19'h01000, S_FR    = 19'h02000, S_ML0   = 19'h04000,
    S_ML1   = 19'h08000, S_MR0   = 19'h10000, S_MR1   = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t state;

  // configuration
  logic        bypass, stereo_enable;
  logic [23:0] phase_step;
  logic [17:0] base_delay;
  logic [15:0] mod_depth, wet_mix;
  logic signed [15:0] feedback_gain;

  assign pready = 1'b1;
  logic pwr;
  assign pwr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0; stereo_enable <= 1'b1; phase_step <= StepReset;
      base_delay <= BaseReset; mod_depth <= DepthReset;
      feedback_gain <= FeedbackReset; wet_mix <= WetReset;
    end else if (pwr) begin
      case (paddr[AddrWidth-1:2])
        REG_BYPASS:   bypass <= pwdata[0];
        REG_STEREO:   stereo_enable <= pwdata[0];
        REG_STEP:     phase_step <= pwdata[23:0];
        REG_BASE:     base_delay <= pwdata[17:0];
        REG_DEPTH:    mod_depth <= pwdata[15:0];
        REG_FEEDBACK: feedback_gain <= pwdata[15:0];
        REG_WET:      wet_mix <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrWidth-1:2])
      REG_BYPASS:   prdata = {31'd0, bypass};
      REG_STEREO:   prdata = {31'd0, stereo_enable};
      REG_STEP:     prdata = {8'd0, phase_step};
      REG_BASE:     prdata = {14'd0, base_delay};
      REG_DEPTH:    prdata = {16'd0, mod_depth};
      REG_FEEDBACK: prdata = {16'd0, feedback_gain};
      REG_WET:      prdata = {16'd0, wet_mix};
      default:      prdata = 32'd0;
    endcase
  end

  // constant LFO table
  logic [15:0] lfo_tab [SineDepth];
  for (genvar k = 0; k < SineDepth; k++) begin : g_lfo
    localparam logic [15:0] Entry = lfo_entry(SineBits'(k));
    assign lfo_tab[k] = Entry;
  end

  // clamped coefficients
  logic [16:0] depth_c, wet_c;
  logic signed [16:0] fb_c;
  always_comb begin
    depth_c = ({1'b0, mod_depth} > UnityQ15) ? UnityQ15 : {1'b0, mod_depth};
    wet_c   = ({1'b0, wet_mix} > UnityQ15) ? UnityQ15 : {1'b0, wet_mix};
    fb_c    = 17'(feedback_gain);
    if (fb_c > FbLimit) fb_c = FbLimit;
    if (fb_c < -FbLimit) fb_c = -FbLimit;
  end

  // frame state
  logic [23:0] lfo_phase;
  logic [AW-1:0] wpos, clr_addr, i0;
  logic [7:0] frac;
  logic signed [15:0] xl, xr, l0, l1, r0, r1, dl, dr;
  logic last;
  logic [15:0] lfo;
  logic [16:0] prod;
  logic [AW+7:0] pos;

  // shared multiplier and accumulator
  logic signed [17:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [43:0] mul_p, acc;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state)
      S_DEP: begin mul_a = 18'(lfo); mul_b = 26'(depth_c); end
      S_DLY: begin mul_a = 18'(prod); mul_b = 26'(base_delay); end
      S_IL0: begin mul_a = 18'(9'd256 - 9'(frac)); mul_b = 26'(l0); end
      S_IL1: begin mul_a = 18'(frac); mul_b = 26'(l1); end
      S_IR0: begin mul_a = 18'(9'd256 - 9'(frac)); mul_b = 26'(r0); end
      S_IR1: begin mul_a = 18'(frac); mul_b = 26'(r1); end
      S_FL:  begin mul_a = 18'(fb_c); mul_b = 26'(dl); end
      S_FR:  begin mul_a = 18'(fb_c); mul_b = 26'(dr); end
      S_ML0: begin mul_a = 18'(wet_c); mul_b = 26'(dl); end
      S_ML1: begin mul_a = 18'(UnityQ15 - wet_c); mul_b = 26'(xl); end
      S_MR0: begin mul_a = 18'(wet_c); mul_b = 26'(dr); end
      S_MR1: begin mul_a = 18'(UnityQ15 - wet_c); mul_b = 26'(xr); end
      default: ;
    endcase
  end

  function automatic logic signed [15:0] sat16(logic signed [43:0] v);
    if (v > 44'sd32767) return 16'sd32767;
    if (v < -44'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // memories
  logic signed [15:0] lmem [DELAY_DEPTH];
  logic signed [15:0] rmem [DELAY_DEPTH];
  logic signed [15:0] lq, rq, lwd, rwd;
  logic [AW-1:0] raddr, waddr;
  logic lwe, rwe;

  always_ff @(posedge clk) begin
    if (lwe) lmem[waddr] <= lwd;
    if (rwe) rmem[waddr] <= rwd;
    lq <= lmem[raddr];
    rq <= rmem[raddr];
  end

  logic signed [43:0] fb_l, fb_r;
  logic [AW+7:0] dly_sum;
  logic [AW+8:0] pos_d;
  always_comb begin
    raddr = (state == S_RD0) ? i0 : i0 + AW'(1);
    waddr = (state == S_CLEAR) ? clr_addr : wpos;
    fb_l = 44'(xl) + (mul_p >>> 15);
    fb_r = 44'(xr) + (mul_p >>> 15);
    lwe = (state == S_CLEAR) || (state == S_FL);
    rwe = (state == S_CLEAR) || (state == S_FR && stereo_enable);
    lwd = (state == S_CLEAR) ? '0 : sat16(fb_l);
    rwd = (state == S_CLEAR) ? '0 : sat16(fb_r);
    dly_sum = '0;
    begin
      logic [36:0] d;
      d = 37'(base_delay) + 37'(mul_p[35:15]);
      dly_sum = (d > 37'(Limit)) ? Limit : (AW+8)'(d);
    end
    pos_d = {1'b0, wpos, 8'd0} - (AW+9)'(dly_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0; lfo_phase <= '0; wpos <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DELAY_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          xl <= s_tdata[15:0]; xr <= s_tdata[31:16]; last <= s_tlast;
          if (bypass) state <= S_OUT;
          else state <= S_LFO;
        end
        S_LFO: begin
          lfo <= lfo_tab[lfo_phase[23 -: SineBits]];
          lfo_phase <= lfo_phase + phase_step;
          state <= S_DEP;
        end
        S_DEP: begin prod <= mul_p[31:15]; state <= S_DLY; end
        S_DLY: begin
          pos <= pos_d[AW+8] ? pos_d[AW+7:0] + ((AW+8)'(DELAY_DEPTH) << 8)
                             : pos_d[AW+7:0];
          state <= S_ADDR;
        end
        S_ADDR: begin i0 <= pos[AW+7:8]; frac <= pos[7:0]; state <= S_RD0; end
        S_RD0: state <= S_RD1;
        S_RD1: begin l0 <= lq; r0 <= rq; state <= S_IL0; end
        S_IL0: begin l1 <= lq; r1 <= rq; acc <= mul_p; state <= S_IL1; end
        S_IL1: begin dl <= 16'((acc + mul_p) >>> 8); state <= S_IR0; end
        S_IR0: begin acc <= mul_p; state <= S_IR1; end
        S_IR1: begin dr <= 16'((acc + mul_p) >>> 8); state <= S_FL; end
        S_FL: state <= S_FR;
        S_FR: state <= S_ML0;
        S_ML0: begin acc <= mul_p; state <= S_ML1; end
        S_ML1: begin
          xl <= sat16((acc + mul_p) >>> 15);
          state <= S_MR0;
        end
        S_MR0: begin acc <= mul_p; state <= S_MR1; end
        S_MR1: begin
          xr <= stereo_enable ? sat16((acc + mul_p) >>> 15) : '0;
          wpos <= wpos + AW'(1);
          state <= S_OUT;
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tdata <= {xr, xl}; m_tlast <= last; m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(state == S_CLEAR)) else $error("ready during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("output dropped");
  a_wpos_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MR1) |=> wpos == $past(wpos) + AW'(1)) else $error("wpos step");
endmodule

// ----- tb/tb.sv -----
// Testbench for stereo_flanger_core: frame stream with random gaps and stalls, checked against a local model.
`timescale 1ns / 100ps

module tb;
  import sfl_pkg::*;

  typedef struct packed {
    logic       last;
    logic [15:0] right;
    logic [15:0] left;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stereo_flanger_core dut (.*);

  always #10 clk = ~clk;

  // model state
  logic [15:0] sine_rom [SineDepth];
  logic [23:0] phase_acc;
  logic [10:0] wr_pos;
  logic signed [15:0] left_line [2048];
  logic signed [15:0] right_line [2048];
  logic        cfg_bypass, cfg_stereo;
  logic [23:0] cfg_step;
  logic [17:0] cfg_base;
  logic [15:0] cfg_depth, cfg_wet;
  logic signed [15:0] cfg_fb;

  frame_t pending_frames [$];
  frame_t expected_frames [$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     in_wait = 0, out_wait = 0;

  function automatic longint fdiv(longint v, int s);
    return v >>> s;  // arithmetic shift is floor
  endfunction

  function automatic longint sat16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint qsine(longint unsigned t);
    longint unsigned t2, v, s;
    t2 = (t * t) >> 16;
    v = 172272;
    v = 5026995 - ((t2 * v) >> 16);
    v = 85569306 - ((t2 * v) >> 16);
    v = 693598669 - ((t2 * v) >> 16);
    v = 1686629713 - ((t2 * v) >> 16);
    s = (t * v) >> 16;
    s = (s + 16384) >> 15;
    return s > 32768 ? 32768 : s;
  endfunction

  task automatic build_sine();
    longint unsigned u, q, t;
    longint s;
    for (int k = 0; k < SineDepth; k++) begin
      u = (longint'(k) * 262144) / SineDepth;
      q = (u >> 16) & 3;
      t = u & 'hFFFF;
      if (q[0]) t = 65536 - t;
      s = qsine(t);
      if (q >= 2) s = -s;
      sine_rom[k] = 16'((32768 + s) >> 1);
    end
  endtask

  task automatic model_reset();
    phase_acc = '0; wr_pos = '0;
    for (int i = 0; i < 2048; i++) begin
      left_line[i] = '0; right_line[i] = '0;
    end
    cfg_bypass = 0; cfg_stereo = 1; cfg_step = StepReset; cfg_base = BaseReset;
    cfg_depth = DepthReset; cfg_fb = FeedbackReset; cfg_wet = WetReset;
  endtask

  function automatic frame_t flange(frame_t x);
    frame_t y;
    longint xl, xr, lfo, depth, prod, dly, pos, frac, fb, wet, dl, dr;
    int i0, i1;
    xl = $signed(x.left); xr = $signed(x.right);
    y.last = x.last;
    if (cfg_bypass) begin
      y.left = x.left; y.right = x.right;
      return y;
    end
    lfo = sine_rom[phase_acc[23:16]];
    phase_acc = phase_acc + cfg_step;
    depth = cfg_depth > 32768 ? 32768 : cfg_depth;
    prod = (lfo * depth) >> 15;
    dly = cfg_base + ((longint'(cfg_base) * prod) >> 15);
    if (dly > (2046 << 8)) dly = 2046 << 8;
    pos = (longint'(wr_pos) << 8) - dly;
    if (pos < 0) pos += 2048 << 8;
    i0 = int'((pos >> 8) % 2048);
    i1 = (i0 + 1) % 2048;
    frac = pos & 255;
    fb = cfg_fb;
    if (fb > 32440) fb = 32440;
    if (fb < -32440) fb = -32440;
    wet = cfg_wet > 32768 ? 32768 : cfg_wet;
    dl = fdiv(longint'(left_line[i0]) * (256 - frac) + longint'(left_line[i1]) * frac, 8);
    left_line[wr_pos] = 16'(sat16(xl + fdiv(dl * fb, 15)));
    y.left = 16'(sat16(fdiv(xl * (32768 - wet) + dl * wet, 15)));
    y.right = '0;
    if (cfg_stereo) begin
      dr = fdiv(longint'(right_line[i0]) * (256 - frac) + longint'(right_line[i1]) * frac, 8);
      right_line[wr_pos] = 16'(sat16(xr + fdiv(dr * fb, 15)));
      y.right = 16'(sat16(fdiv(xr * (32768 - wet) + dr * wet, 15)));
    end
    wr_pos = 11'(wr_pos + 1);
    return y;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_wait <= $urandom_range(0, 10);
    end else if (s_tvalid && !s_tready) begin
      // hold
    end else begin
      if (s_tvalid) expected_frames.push_back(flange(frame_t'({s_tlast, s_tdata})));
      if (pending_frames.size() > 0 && in_wait == 0) begin
        s_tvalid <= 1'b1;
        {s_tlast, s_tdata} <= pending_frames.pop_front();
        in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        s_tvalid <= 1'b0;
        if (in_wait > 0) in_wait <= in_wait - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata};
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output frame %h", got);
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: L exp %h got %h, R exp %h got %h, last exp %b got %b",
                       want.left, got.left, want.right, got.right, want.last, got.last);
          end
        end
        out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 8000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrWidth'(4 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BYPASS:   cfg_bypass = value[0];
      REG_STEREO:   cfg_stereo = value[0];
      REG_STEP:     cfg_step = value[23:0];
      REG_BASE:     cfg_base = value[17:0];
      REG_DEPTH:    cfg_depth = value[15:0];
      REG_FEEDBACK: cfg_fb = value[15:0];
      REG_WET:      cfg_wet = value[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || s_tvalid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    frame_t f;
    for (int i = 0; i < n; i++) begin
      f.left = rand_sample(); f.right = rand_sample(); f.last = $urandom_range(0, 1);
      pending_frames.push_back(f);
    end
  endtask

  task automatic random_config();
    reg_write(REG_BYPASS, ($urandom_range(0, 7) == 0));
    reg_write(REG_STEREO, $urandom_range(0, 3) != 0);
    reg_write(REG_STEP, ($urandom_range(0, 1)) ? $urandom_range(0, 100000) : $urandom);
    case ($urandom_range(0, 3))
      0: reg_write(REG_BASE, 18'h3FFFF);
      1: reg_write(REG_BASE, $urandom_range(0, 255));
      default: reg_write(REG_BASE, $urandom_range(0, 2047 * 256) & 18'h3FFFF);
    endcase
    reg_write(REG_DEPTH, $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 32768));
    reg_write(REG_FEEDBACK, $urandom_range(0, 3) == 0 ? 16'h8000 : 16'($urandom));
    reg_write(REG_WET, $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 32768));
  endtask

  initial begin
    frame_t f;
    build_sine();
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes at reset settings, including zero delay reading oldest
    f.last = 1; f.left = 16'h7FFF; f.right = 16'h8000; pending_frames.push_back(f);
    f.last = 0; f.left = 16'h8000; f.right = 16'h7FFF; pending_frames.push_back(f);
    f.left = 16'h0000; f.right = 16'hFFFF; pending_frames.push_back(f);
    f.left = 16'h5555; f.right = 16'hAAAA; f.last = 1; pending_frames.push_back(f);
    drain();
    reg_write(REG_BASE, 18'd0);
    reg_write(REG_DEPTH, 16'hFFFF);
    reg_write(REG_FEEDBACK, 16'h7FFF);
    reg_write(REG_WET, 16'hFFFF);
    reg_write(REG_STEP, 24'hFFFFFF);
    queue_random(6);
    drain();
    reg_write(REG_BASE, 18'h3FFFF);
    reg_write(REG_FEEDBACK, 16'h8000);
    reg_write(REG_WET, 16'd0);
    reg_write(REG_STEREO, 1'b0);
    queue_random(6);
    drain();
    reg_write(REG_BYPASS, 1'b1);
    queue_random(4);
    drain();
    reg_write(REG_BYPASS, 1'b0);
    reg_write(REG_STEREO, 1'b1);
    reg_write(REG_DEPTH, 16'd0);
    reg_write(REG_WET, 16'd32768);
    reg_write(REG_FEEDBACK, 16'd32440);
    queue_random(4);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      queue_random(50);
      drain();
    end

    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
